@@ rtl/core/cafvg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cafvg_pkg;

  // Segment count is clamped to this range before the run starts.
  localparam int MAX_SEGMENTS = 62;
  // Number of CORDIC micro-rotations per rim point.
  localparam int CORDIC_STEPS = 16;
  // Vertex coordinates saturate to this many signed bits.
  localparam int COORD_BITS   = 16;

  localparam int ITER_W      = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W  = 5;
  localparam int ANG_W       = 33;
  localparam int CS_W        = 33;
  localparam int PROD_W      = 48;
  localparam int SUM_W       = 20;
  localparam int QUOT_W      = 31;
  localparam int DIV_CNT_W   = $clog2(QUOT_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Angles are in units of 2^-20 degree.
  localparam logic signed [ANG_W-1:0] ANG_FULL     = 33'sd377487360;
  localparam logic signed [ANG_W-1:0] ANG_HALF     = 33'sd188743680;
  localparam logic signed [ANG_W-1:0] ANG_NEG_HALF = -33'sd188743680;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER  = 33'sd94371840;
  localparam logic signed [ANG_W-1:0] ANG_NEG_QUARTER = -33'sd94371840;

  // CORDIC start vector length, 0.607252935 in Q1.30.
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;
  // One half in the Q1.30 product scale, for round-half-up.
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 48'sd536870912;

  localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((2 ** (COORD_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] COORD_MIN = -COORD_MAX - SUM_W'(1);

  // One arc request after setup, handed from the front to the back.
  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [14:0]        radius;
    logic [31:0]        angle_start;
    logic [31:0]        angle_step;
    logic [5:0]         vertex_count;
  } arc_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_DIVIDE,
    FRONT_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BACK_IDLE,
    BACK_CENTER,
    BACK_REDUCE,
    BACK_FOLD,
    BACK_ROTATE,
    BACK_PRODUCT,
    BACK_EMIT
  } back_state_t;

  // round(atan(2^-i) in degrees * 2^20)
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 33'sd47185920;
      5'd1:    v = 33'sd27855475;
      5'd2:    v = 33'sd14718068;
      5'd3:    v = 33'sd7471121;
      5'd4:    v = 33'sd3750058;
      5'd5:    v = 33'sd1876857;
      5'd6:    v = 33'sd938658;
      5'd7:    v = 33'sd469357;
      5'd8:    v = 33'sd234682;
      5'd9:    v = 33'sd117342;
      5'd10:   v = 33'sd58671;
      5'd11:   v = 33'sd29335;
      5'd12:   v = 33'sd14668;
      5'd13:   v = 33'sd7334;
      5'd14:   v = 33'sd3667;
      5'd15:   v = 33'sd1833;
      5'd16:   v = 33'sd917;
      5'd17:   v = 33'sd458;
      5'd18:   v = 33'sd229;
      5'd19:   v = 33'sd115;
      5'd20:   v = 33'sd57;
      5'd21:   v = 33'sd29;
      5'd22:   v = 33'sd14;
      5'd23:   v = 33'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] clamp_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    if (v > COORD_MAX) begin
      c = COORD_MAX;
    end else if (v < COORD_MIN) begin
      c = COORD_MIN;
    end else begin
      c = v;
    end
    return c[15:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cafvg_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Accepts a request, clamps the segment count and works out the angle step
// with a one-bit-per-cycle restoring divider.
module cafvg_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [87:0]              in_tdata,
  input  wire cafvg_pkg::queue_status_t q_stat,
  output logic                          push,
  output cafvg_pkg::arc_job_t           job
);

  cafvg_pkg::front_state_t state_r, state_nxt;

  logic signed [15:0]                  cx_r, cx_nxt;
  logic signed [15:0]                  cy_r, cy_nxt;
  logic [14:0]                         rad_r, rad_nxt;
  logic [31:0]                         start_r, start_nxt;
  logic [5:0]                          segs_r, segs_nxt;
  logic                                neg_r, neg_nxt;
  logic [cafvg_pkg::QUOT_W-1:0]        quot_r, quot_nxt;
  logic [5:0]                          rem_r, rem_nxt;
  logic [cafvg_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;

  logic [5:0]         seg_in;
  logic [5:0]         seg_clamped;
  logic signed [13:0] st_in;
  logic signed [13:0] en_in;
  logic signed [14:0] diff;
  logic [14:0]        diff_mag;
  logic [6:0]         rem_sh;
  logic               rem_ge;
  logic [31:0]        step_mag;

  always_comb begin
    seg_in = in_tdata[52:47];
    st_in  = $signed(in_tdata[66:53]);
    en_in  = $signed(in_tdata[80:67]);
    if (seg_in == 6'd0) begin
      seg_clamped = 6'd1;
    end else if (seg_in > 6'(cafvg_pkg::MAX_SEGMENTS)) begin
      seg_clamped = 6'(cafvg_pkg::MAX_SEGMENTS);
    end else begin
      seg_clamped = seg_in;
    end
    diff     = 15'(en_in) - 15'(st_in);
    diff_mag = diff[14] ? 15'(-diff) : 15'(diff);
    rem_sh   = {rem_r, quot_r[cafvg_pkg::QUOT_W-1]};
    rem_ge   = rem_sh >= {1'b0, segs_r};
    step_mag = {1'b0, quot_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cafvg_pkg::FRONT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    rad_r   <= rad_nxt;
    start_r <= start_nxt;
    segs_r  <= segs_nxt;
    neg_r   <= neg_nxt;
    quot_r  <= quot_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    rad_nxt   = rad_r;
    start_nxt = start_r;
    segs_nxt  = segs_r;
    neg_nxt   = neg_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      cafvg_pkg::FRONT_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cx_nxt    = $signed(in_tdata[15:0]);
          cy_nxt    = $signed(in_tdata[31:16]);
          rad_nxt   = in_tdata[46:32];
          start_nxt = {{2{st_in[13]}}, st_in, 16'h0000};
          segs_nxt  = seg_clamped;
          neg_nxt   = diff[14];
          quot_nxt  = {diff_mag, 16'h0000};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = cafvg_pkg::FRONT_DIVIDE;
        end
      end
      cafvg_pkg::FRONT_DIVIDE: begin
        rem_nxt  = rem_ge ? 6'(rem_sh - {1'b0, segs_r}) : rem_sh[5:0];
        quot_nxt = {quot_r[cafvg_pkg::QUOT_W-2:0], rem_ge};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == cafvg_pkg::DIV_CNT_W'(cafvg_pkg::QUOT_W - 1)) begin
          state_nxt = cafvg_pkg::FRONT_PUSH;
        end
      end
      cafvg_pkg::FRONT_PUSH: begin
        if (!q_stat.full) begin
          push      = 1'b1;
          state_nxt = cafvg_pkg::FRONT_IDLE;
        end
      end
      default: begin
        state_nxt = cafvg_pkg::FRONT_IDLE;
      end
    endcase
  end

  always_comb begin
    job.center_x     = cx_r;
    job.center_y     = cy_r;
    job.radius       = rad_r;
    job.angle_start  = start_r;
    job.angle_step   = neg_r ? 32'(-step_mag) : step_mag;
    job.vertex_count = segs_r + 6'd1;
  end

endmodule

`default_nettype wire

@@ rtl/core/cafvg_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Short job queue between the front and the back.
module cafvg_queue (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire cafvg_pkg::arc_job_t       push_job,
  input  wire logic                      pop,
  output cafvg_pkg::arc_job_t            pop_job,
  output cafvg_pkg::queue_status_t       q_stat
);

  cafvg_pkg::arc_job_t              slot_r [cafvg_pkg::QUEUE_DEPTH];
  logic [cafvg_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [cafvg_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [cafvg_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                             do_push;
  logic                             do_pop;

  always_comb begin
    q_stat.full  = count_r == cafvg_pkg::QCNT_W'(cafvg_pkg::QUEUE_DEPTH);
    q_stat.empty = count_r == '0;
    do_push      = push && !q_stat.full;
    do_pop       = pop && !q_stat.empty;
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    count_nxt    = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == cafvg_pkg::QPTR_W'(cafvg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == cafvg_pkg::QPTR_W'(cafvg_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
    pop_job = slot_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cafvg_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Walks one job: emits the center, then for each rim point reduces the angle,
// runs the iterative CORDIC, scales by the radius and emits the vertex.
module cafvg_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cafvg_pkg::arc_job_t      job,
  input  wire cafvg_pkg::queue_status_t q_stat,
  output logic                          pop,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [39:0]                   out_tdata,
  output logic                          out_tlast
);

  cafvg_pkg::back_state_t state_r, state_nxt;

  logic signed [15:0]                   cx_r, cx_nxt;
  logic signed [15:0]                   cy_r, cy_nxt;
  logic [14:0]                          rad_r, rad_nxt;
  logic [31:0]                          acc_r, acc_nxt;
  logic [31:0]                          step_r, step_nxt;
  logic [5:0]                           left_r, left_nxt;
  logic [5:0]                           num_r, num_nxt;
  logic signed [cafvg_pkg::ANG_W-1:0]   z_r, z_nxt;
  logic signed [cafvg_pkg::CS_W-1:0]    x_r, x_nxt;
  logic signed [cafvg_pkg::CS_W-1:0]    y_r, y_nxt;
  logic                                 neg_r, neg_nxt;
  logic [cafvg_pkg::ITER_W-1:0]         iter_r, iter_nxt;
  logic signed [cafvg_pkg::PROD_W-1:0]  prod_x_r, prod_x_nxt;
  logic signed [cafvg_pkg::PROD_W-1:0]  prod_y_r, prod_y_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [15:0]                   out_x_r, out_x_nxt;
  logic signed [15:0]                   out_y_r, out_y_nxt;
  logic [5:0]                           out_num_r, out_num_nxt;
  logic                                 out_last_r, out_last_nxt;

  logic                                 out_free;
  logic signed [cafvg_pkg::CS_W-1:0]    x_sh;
  logic signed [cafvg_pkg::CS_W-1:0]    y_sh;
  logic signed [cafvg_pkg::ANG_W-1:0]   atan_val;
  logic signed [cafvg_pkg::CS_W-1:0]    cos_full;
  logic signed [cafvg_pkg::CS_W-1:0]    sin_full;
  logic signed [31:0]                   cos_val;
  logic signed [31:0]                   sin_val;
  logic signed [15:0]                   rad_s;
  logic signed [cafvg_pkg::PROD_W-1:0]  rnd_x;
  logic signed [cafvg_pkg::PROD_W-1:0]  rnd_y;
  logic signed [cafvg_pkg::SUM_W-1:0]   sum_x;
  logic signed [cafvg_pkg::SUM_W-1:0]   sum_y;
  logic [31:0]                          acc_step;

  always_comb begin
    out_free = !out_valid_r || out_tready;
    x_sh     = x_r >>> iter_r;
    y_sh     = y_r >>> iter_r;
    atan_val = cafvg_pkg::atan_entry(cafvg_pkg::ATAN_IDX_W'(iter_r));
    cos_full = neg_r ? -x_r : x_r;
    sin_full = neg_r ? -y_r : y_r;
    cos_val  = $signed(cos_full[31:0]);
    sin_val  = $signed(sin_full[31:0]);
    rad_s    = $signed({1'b0, rad_r});
    rnd_x    = prod_x_r + cafvg_pkg::ROUND_HALF;
    rnd_y    = prod_y_r + cafvg_pkg::ROUND_HALF;
    sum_x    = cafvg_pkg::SUM_W'(cx_r) + cafvg_pkg::SUM_W'($signed(rnd_x[47:30]));
    sum_y    = cafvg_pkg::SUM_W'(cy_r) + cafvg_pkg::SUM_W'($signed(rnd_y[47:30]));
    acc_step = acc_r + step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cafvg_pkg::BACK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    rad_r      <= rad_nxt;
    acc_r      <= acc_nxt;
    step_r     <= step_nxt;
    left_r     <= left_nxt;
    num_r      <= num_nxt;
    z_r        <= z_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    neg_r      <= neg_nxt;
    iter_r     <= iter_nxt;
    prod_x_r   <= prod_x_nxt;
    prod_y_r   <= prod_y_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rad_nxt       = rad_r;
    acc_nxt       = acc_r;
    step_nxt      = step_r;
    left_nxt      = left_r;
    num_nxt       = num_r;
    z_nxt         = z_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    neg_nxt       = neg_r;
    iter_nxt      = iter_r;
    prod_x_nxt    = prod_x_r;
    prod_y_nxt    = prod_y_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    unique case (state_r)
      cafvg_pkg::BACK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          cx_nxt    = job.center_x;
          cy_nxt    = job.center_y;
          rad_nxt   = job.radius;
          acc_nxt   = job.angle_start;
          step_nxt  = job.angle_step;
          left_nxt  = job.vertex_count;
          state_nxt = cafvg_pkg::BACK_CENTER;
        end
      end
      cafvg_pkg::BACK_CENTER: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = cafvg_pkg::clamp_coord(cafvg_pkg::SUM_W'(cx_r));
          out_y_nxt     = cafvg_pkg::clamp_coord(cafvg_pkg::SUM_W'(cy_r));
          out_num_nxt   = 6'd0;
          out_last_nxt  = 1'b0;
          num_nxt       = 6'd1;
          z_nxt         = $signed({acc_r[31], acc_r});
          state_nxt     = cafvg_pkg::BACK_REDUCE;
        end
      end
      cafvg_pkg::BACK_REDUCE: begin
        // Bring the angle into [-180, 180) degrees, one full turn per cycle.
        if (z_r >= cafvg_pkg::ANG_HALF) begin
          z_nxt = z_r - cafvg_pkg::ANG_FULL;
        end else if (z_r < cafvg_pkg::ANG_NEG_HALF) begin
          z_nxt = z_r + cafvg_pkg::ANG_FULL;
        end else begin
          state_nxt = cafvg_pkg::BACK_FOLD;
        end
      end
      cafvg_pkg::BACK_FOLD: begin
        // Angles beyond a quarter turn are rotated by half a turn and the
        // result is negated afterwards.
        if (z_r > cafvg_pkg::ANG_QUARTER) begin
          z_nxt   = z_r - cafvg_pkg::ANG_HALF;
          neg_nxt = 1'b1;
        end else if (z_r < cafvg_pkg::ANG_NEG_QUARTER) begin
          z_nxt   = z_r + cafvg_pkg::ANG_HALF;
          neg_nxt = 1'b1;
        end else begin
          neg_nxt = 1'b0;
        end
        x_nxt     = cafvg_pkg::CORDIC_GAIN;
        y_nxt     = '0;
        iter_nxt  = '0;
        state_nxt = cafvg_pkg::BACK_ROTATE;
      end
      cafvg_pkg::BACK_ROTATE: begin
        if (!z_r[cafvg_pkg::ANG_W-1]) begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - atan_val;
        end else begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + atan_val;
        end
        iter_nxt = iter_r + 1'b1;
        if (iter_r == cafvg_pkg::ITER_W'(cafvg_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = cafvg_pkg::BACK_PRODUCT;
        end
      end
      cafvg_pkg::BACK_PRODUCT: begin
        prod_x_nxt = rad_s * cos_val;
        prod_y_nxt = rad_s * sin_val;
        state_nxt  = cafvg_pkg::BACK_EMIT;
      end
      cafvg_pkg::BACK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = cafvg_pkg::clamp_coord(sum_x);
          out_y_nxt     = cafvg_pkg::clamp_coord(sum_y);
          out_num_nxt   = num_r;
          out_last_nxt  = left_r == 6'd1;
          num_nxt       = num_r + 6'd1;
          left_nxt      = left_r - 6'd1;
          acc_nxt       = acc_step;
          z_nxt         = $signed({acc_step[31], acc_step});
          state_nxt     = (left_r == 6'd1) ? cafvg_pkg::BACK_IDLE : cafvg_pkg::BACK_REDUCE;
        end
      end
      default: begin
        state_nxt = cafvg_pkg::BACK_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_num_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ rtl/core/circle_arc_fan_vertex_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+----------------------------------------------
// in_      | input     | in_tvalid/tready   | tdata: center_x, center_y, arc_radius,
//          |           |                    |        segment_count, start_angle, end_angle
// out_     | output    | out_tvalid/tready  | tdata: vertex_x, vertex_y, vertex_number;
//          |           |                    | tlast: last_vertex
//
// The front works out the angle step with the bit-serial division and then queues the job, so it
// takes no new request until the previous job has been pushed into the queue.
// The back pops a job and emits the center, then for each of up to 63 rim points it wraps
// the angle, folds it, runs the CORDIC rotations, multiplies by the radius and emits the vertex.
// Reset is synchronous and active low and clears the control state and the output valid;
// a stalled output holds the back, and a full queue holds the front off in_tready.
module circle_arc_fan_vertex_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [15:0] center_x, [31:16] center_y, [46:32] arc_radius, [52:47] segment_count,
  // [66:53] start_angle, [80:67] end_angle, [87:81] zero
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] vertex_x, [31:16] vertex_y, [37:32] vertex_number, [39:38] zero
  output logic [39:0]      out_tdata,
  output logic             out_tlast
);

  cafvg_pkg::arc_job_t      front_job;
  cafvg_pkg::arc_job_t      back_job;
  cafvg_pkg::queue_status_t q_stat;
  logic                     q_push;
  logic                     q_pop;

  cafvg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (q_push),
    .job       (front_job)
  );

  cafvg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (front_job),
    .pop      (q_pop),
    .pop_job  (back_job),
    .q_stat   (q_stat)
  );

  cafvg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (back_job),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // The divider keeps the front busy right after every accepted request.
  a_front_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready
  ) else $error("front accepted a request while dividing");

  // The center vertex never closes a run.
  a_last_not_center: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[37:32] != 6'd0
  ) else $error("last vertex marked on the center");

  // The queue occupancy flags never contradict each other.
  a_queue_flags: assert property (
    @(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty)
  ) else $error("queue reports full and empty together");

endmodule

`default_nettype wire
